// ===== rtl/core/cfq_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive queue package
// Shared frame types, operation codes and length normalization.
// ----------------------------------------------------------------------------
package cfq_pkg;

    localparam int DEFAULT_QUEUE_DEPTH = 16;
    localparam int ID_W                = 11;
    localparam int LEN_W               = 4;
    localparam int DATA_W              = 64;
    localparam int COUNT_W             = 32;
    localparam int MAX_BYTES           = 8;

    // Item operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // One stored frame
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } frame_t;

    // Decisions from the ring control for one accepted item
    typedef struct packed {
        logic store;    // push written into the ring
        logic fetch;    // pop returns a frame
        logic drop;     // push lost because the ring is full
    } ring_op_t;

    // Clamp the length code to 8 and clear bytes beyond it
    function automatic frame_t normalize_frame(
        input logic [ID_W-1:0]   id,
        input logic [LEN_W-1:0]  raw_len,
        input logic [DATA_W-1:0] data
    );
        frame_t f;
        logic [LEN_W-1:0] len;
        len = (raw_len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : raw_len;
        f.id  = id;
        f.len = len;
        for (int b = 0; b < MAX_BYTES; b++)
        begin
            f.data[b*8 +: 8] = (LEN_W'(b) < len) ? data[b*8 +: 8] : 8'h00;
        end
        return f;
    endfunction

endpackage

// ===== rtl/core/can_rx_frame_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive frame queue
// Ring of standard CAN frames with drop-newest overflow handling.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready) carries one item: op selects push of a
//   received frame or pop of the oldest stored frame. Extended frames are
//   ignored on push; standard frames are clamped to 8 bytes and stored.
//   A push into a full ring (QUEUE_DEPTH-1 frames held) is dropped and
//   counted in overflow_count, which wraps at 32 bits.
//   Output channel (out_valid/out_ready) returns exactly one result per item.
//   Pops report no frame while the enabled register is 0 or the ring is empty.
//   The result is registered and presented in the cycle after the item is accepted.
//   Throughput: one item per cycle while out_ready holds high, set by the
//   single result register, which is reloaded in the same cycle its result
//   is taken; each item uses at most one slot write or one slot read.
//   Stall: while out_valid is high and out_ready low, in_ready drops and the
//   result holds. Reset empties the ring, clears the counter and the enabled
//   register; slot contents are not cleared and are never read unwritten.
//   cfg_write_en writes cfg_write_data to the enabled register at once.
// ----------------------------------------------------------------------------
module can_rx_frame_queue #(
    parameter int QUEUE_DEPTH = cfq_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write_en,
    input  logic                          cfg_write_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic                          op,
    input  logic                          is_extended,
    input  logic [cfq_pkg::ID_W-1:0]      frame_id,
    input  logic [cfq_pkg::LEN_W-1:0]     raw_length,
    input  logic [cfq_pkg::DATA_W-1:0]    payload,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          pop_valid,
    output logic [cfq_pkg::ID_W-1:0]      out_id,
    output logic [cfq_pkg::LEN_W-1:0]     out_length,
    output logic [cfq_pkg::DATA_W-1:0]    out_data,
    output logic                          dropped,
    output logic [cfq_pkg::COUNT_W-1:0]   overflow_count
);
    import cfq_pkg::*;

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

    logic             enabled_reg, enabled_next;
    logic             out_valid_reg, out_valid_next;
    logic             pop_valid_reg, pop_valid_next;
    logic             dropped_reg, dropped_next;
    logic             accept;
    ring_op_t         ring_op;
    logic [IDX_W-1:0] wr_addr, rd_addr;
    frame_t           rd_frame;

    // Handshake
    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // Ring indices and drop counter
    cfq_ring_ctrl #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_ring_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .accept      (accept),
        .op          (op),
        .is_extended (is_extended),
        .enabled     (enabled_reg),
        .ring_op     (ring_op),
        .wr_addr     (wr_addr),
        .rd_addr     (rd_addr),
        .drop_total  (overflow_count)
    );

    // Slot memory
    cfq_frame_store #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_frame_store (
        .clk        (clk),
        .wr_en      (ring_op.store),
        .wr_addr    (wr_addr),
        .frame_id   (frame_id),
        .raw_length (raw_length),
        .payload    (payload),
        .rd_en      (ring_op.fetch),
        .rd_addr    (rd_addr),
        .rd_frame   (rd_frame)
    );

    // Config register and result flags
    always_comb
    begin
        enabled_next   = cfg_write_en ? cfg_write_data : enabled_reg;
        out_valid_next = accept ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
        pop_valid_next = accept ? ring_op.fetch : pop_valid_reg;
        dropped_next   = accept ? ring_op.drop : dropped_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            pop_valid_reg <= 1'b0;
            dropped_reg   <= 1'b0;
        end
        else
        begin
            enabled_reg   <= enabled_next;
            out_valid_reg <= out_valid_next;
            pop_valid_reg <= pop_valid_next;
            dropped_reg   <= dropped_next;
        end
    end

    // Frame fields read as zero unless a frame was returned
    assign out_valid  = out_valid_reg;
    assign pop_valid  = pop_valid_reg;
    assign dropped    = dropped_reg;
    assign out_id     = pop_valid_reg ? rd_frame.id : '0;
    assign out_length = pop_valid_reg ? rd_frame.len : '0;
    assign out_data   = pop_valid_reg ? rd_frame.data : '0;

endmodule

// ===== rtl/core/cfq_ring_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive queue ring control
// Head and tail indices, full and empty tests, and the drop counter.
// ----------------------------------------------------------------------------
module cfq_ring_ctrl #(
    parameter int QUEUE_DEPTH = cfq_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          accept,
    input  logic                          op,
    input  logic                          is_extended,
    input  logic                          enabled,
    output cfq_pkg::ring_op_t             ring_op,
    output logic [IDX_W-1:0]              wr_addr,
    output logic [IDX_W-1:0]              rd_addr,
    output logic [cfq_pkg::COUNT_W-1:0]   drop_total
);
    import cfq_pkg::*;

    logic [IDX_W-1:0]   write_index_reg, write_index_next;
    logic [IDX_W-1:0]   read_index_reg, read_index_next;
    logic [COUNT_W-1:0] drop_total_reg, drop_total_next;
    logic [IDX_W-1:0]   wr_adv, rd_adv;
    logic               full, empty;

    // Advance modulo the ring depth
    assign wr_adv = (write_index_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : write_index_reg + 1'b1;
    assign rd_adv = (read_index_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : read_index_reg + 1'b1;
    assign full   = (wr_adv == read_index_reg);
    assign empty  = (read_index_reg == write_index_reg);

    // Per-item decision
    always_comb
    begin
        ring_op.store = accept && (op == OP_PUSH) && !is_extended && !full;
        ring_op.drop  = accept && (op == OP_PUSH) && !is_extended && full;
        ring_op.fetch = accept && (op == OP_POP) && enabled && !empty;
    end

    always_comb
    begin
        write_index_next = ring_op.store ? wr_adv : write_index_reg;
        read_index_next  = ring_op.fetch ? rd_adv : read_index_reg;
        drop_total_next  = ring_op.drop ? drop_total_reg + 1'b1 : drop_total_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            write_index_reg <= '0;
            read_index_reg  <= '0;
            drop_total_reg  <= '0;
        end
        else
        begin
            write_index_reg <= write_index_next;
            read_index_reg  <= read_index_next;
            drop_total_reg  <= drop_total_next;
        end
    end

    assign wr_addr    = write_index_reg;
    assign rd_addr    = read_index_reg;
    assign drop_total = drop_total_reg;

endmodule

// ===== rtl/core/cfq_frame_store.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive queue frame store
// Slot memory with one write port and one registered read port.
// ----------------------------------------------------------------------------
module cfq_frame_store #(
    parameter int QUEUE_DEPTH = cfq_pkg::DEFAULT_QUEUE_DEPTH,
    localparam int IDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
    input  logic                          clk,
    input  logic                          wr_en,
    input  logic [IDX_W-1:0]              wr_addr,
    input  logic [cfq_pkg::ID_W-1:0]      frame_id,
    input  logic [cfq_pkg::LEN_W-1:0]     raw_length,
    input  logic [cfq_pkg::DATA_W-1:0]    payload,
    input  logic                          rd_en,
    input  logic [IDX_W-1:0]              rd_addr,
    output cfq_pkg::frame_t               rd_frame
);
    import cfq_pkg::*;

    frame_t slot_mem [QUEUE_DEPTH];
    frame_t rd_frame_reg;

    // Write the normalized frame
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_mem[wr_addr] <= normalize_frame(frame_id, raw_length, payload);
        end
    end

    // Registered read, held until the next pop
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_frame_reg <= slot_mem[rd_addr];
        end
    end

    assign rd_frame = rd_frame_reg;

endmodule

// ===== tb/sv/can_rx_frame_queue_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// CAN receive frame queue testbench
// Drives push and pop items through the valid/ready input channel and checks
// every result against a shadow ring kept in the testbench. A short directed
// table covers the field extremes, extended frames, length clamping, empty
// and disabled pops. Random phases follow, each with its own push/pop mix and
// enable setting, so the ring fills, wraps and drops frames. Both channels
// idle and stall at random.
// ----------------------------------------------------------------------------
module can_rx_frame_queue_tb;

    import cfq_pkg::*;

    localparam int DEPTH        = DEFAULT_QUEUE_DEPTH;
    localparam int IDLE_LIMIT   = 4000;
    localparam int PHASE_COUNT  = 9;
    localparam int PHASE_ITEMS  = 150;

    // Per-phase enable and push percentage for the random part
    localparam logic [PHASE_COUNT-1:0] PHASE_EN = 9'b1_0110_1101;
    localparam logic [PHASE_COUNT-1:0][7:0] PHASE_PUSH_PCT =
        {8'd50, 8'd15, 8'd70, 8'd40, 8'd90, 8'd60, 8'd25, 8'd85, 8'd90};

    // One input item
    typedef struct packed {
        logic              op;
        logic              ext;
        logic [ID_W-1:0]   id;
        logic [LEN_W-1:0]  len;
        logic [DATA_W-1:0] data;
    } rx_item_t;

    // One result item
    typedef struct packed {
        logic               pop_valid;
        logic [ID_W-1:0]    id;
        logic [LEN_W-1:0]   len;
        logic [DATA_W-1:0]  data;
        logic               dropped;
        logic [COUNT_W-1:0] count;
    } rx_result_t;

    typedef enum logic {STEP_ITEM, STEP_ENABLE} step_kind_e;

    // One row of the directed table
    typedef struct {
        step_kind_e kind;
        logic       en;
        rx_item_t   item;
        bit         typed;
        rx_result_t want;
    } plan_step_t;

    localparam rx_result_t NO_FRAME = '0;

    logic                clk            = 1'b0;
    logic                rst_n          = 1'b0;
    logic                cfg_write_en   = 1'b0;
    logic                cfg_write_data = 1'b0;
    logic                in_valid       = 1'b0;
    logic                in_ready;
    logic                op             = OP_PUSH;
    logic                is_extended    = 1'b0;
    logic [ID_W-1:0]     frame_id       = '0;
    logic [LEN_W-1:0]    raw_length     = '0;
    logic [DATA_W-1:0]   payload        = '0;
    logic                out_valid;
    logic                out_ready      = 1'b0;
    logic                pop_valid;
    logic [ID_W-1:0]     out_id;
    logic [LEN_W-1:0]    out_length;
    logic [DATA_W-1:0]   out_data;
    logic                dropped;
    logic [COUNT_W-1:0]  overflow_count;

    // Shadow ring state
    logic [ID_W-1:0]     shadow_id   [DEPTH];
    logic [LEN_W-1:0]    shadow_len  [DEPTH];
    logic [DATA_W-1:0]   shadow_data [DEPTH];
    int                  shadow_wr;
    int                  shadow_rd;
    logic [COUNT_W-1:0]  shadow_drops;
    logic                shadow_enabled;

    rx_result_t          pending_results[$];
    plan_step_t          plan[$];
    int                  mismatches;
    int                  burst_left;
    int                  idle_cycles;
    logic [15:0]         rx_cycle;
    logic [1:0]          rx_mode;

    can_rx_frame_queue #(
        .QUEUE_DEPTH    (DEPTH)
    ) u_top (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .op             (op),
        .is_extended    (is_extended),
        .frame_id       (frame_id),
        .raw_length     (raw_length),
        .payload        (payload),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .pop_valid      (pop_valid),
        .out_id         (out_id),
        .out_length     (out_length),
        .out_data       (out_data),
        .dropped        (dropped),
        .overflow_count (overflow_count)
    );

    // Clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // Shadow ring: apply one item, return its result
    function automatic rx_result_t rx_queue_predict(input rx_item_t it);
        rx_result_t       r;
        int               nxt;
        logic [LEN_W-1:0] clen;
        logic [DATA_W-1:0] keep;
        r = '0;
        if (it.op == OP_PUSH)
        begin
            if (!it.ext)
            begin
                nxt = (shadow_wr + 1) % DEPTH;
                if (nxt == shadow_rd)
                begin
                    shadow_drops = shadow_drops + 1'b1;
                    r.dropped    = 1'b1;
                end
                else
                begin
                    clen = (it.len > LEN_W'(MAX_BYTES)) ? LEN_W'(MAX_BYTES) : it.len;
                    keep = (clen == LEN_W'(MAX_BYTES)) ? '1 :
                           ((64'd1 << {clen, 3'b000}) - 64'd1);
                    shadow_id[shadow_wr]   = it.id;
                    shadow_len[shadow_wr]  = clen;
                    shadow_data[shadow_wr] = it.data & keep;
                    shadow_wr = nxt;
                end
            end
        end
        else if (shadow_enabled && shadow_rd != shadow_wr)
        begin
            r.pop_valid = 1'b1;
            r.id        = shadow_id[shadow_rd];
            r.len       = shadow_len[shadow_rd];
            r.data      = shadow_data[shadow_rd];
            shadow_rd   = (shadow_rd + 1) % DEPTH;
        end
        r.count = shadow_drops;
        return r;
    endfunction

    function automatic rx_item_t mk_item(input logic o, input logic x,
                                         input logic [ID_W-1:0] id,
                                         input logic [LEN_W-1:0] len,
                                         input logic [DATA_W-1:0] data);
        rx_item_t it;
        it.op   = o;
        it.ext  = x;
        it.id   = id;
        it.len  = len;
        it.data = data;
        return it;
    endfunction

    // Popped frame with no drops so far
    function automatic rx_result_t frame_result(input logic [ID_W-1:0] id,
                                                input logic [LEN_W-1:0] len,
                                                input logic [DATA_W-1:0] data);
        rx_result_t r;
        r           = '0;
        r.pop_valid = 1'b1;
        r.id        = id;
        r.len       = len;
        r.data      = data;
        return r;
    endfunction

    task automatic add_item(input rx_item_t it, input bit typed, input rx_result_t want);
        plan_step_t s;
        s.kind  = STEP_ITEM;
        s.en    = 1'b0;
        s.item  = it;
        s.typed = typed;
        s.want  = want;
        plan.push_back(s);
    endtask

    task automatic add_enable(input logic v);
        plan_step_t s;
        s.kind  = STEP_ENABLE;
        s.en    = v;
        s.item  = '0;
        s.typed = 1'b0;
        s.want  = '0;
        plan.push_back(s);
    endtask

    // Send one item in bursts with random gaps; record its expected result
    task automatic send_item(input rx_item_t it, input bit typed, input rx_result_t want);
        int         gap;
        rx_result_t predicted;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(5, 24) : $urandom_range(0, 3);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 80)
                                                     : $urandom_range(1, 12);
        end
        burst_left--;
        in_valid    <= 1'b1;
        op          <= it.op;
        is_extended <= it.ext;
        frame_id    <= it.id;
        raw_length  <= it.len;
        payload     <= it.data;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        predicted = rx_queue_predict(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    // Write the enable register once the queue has drained
    task automatic set_enable(input logic v);
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_write_en   <= 1'b1;
        cfg_write_data <= v;
        @(posedge clk);
        cfg_write_en   <= 1'b0;
        shadow_enabled = v;
    endtask

    // Receiver ready pattern, mode drawn anew whenever the low byte of rx_cycle is zero
    always @(posedge clk)
    begin
        rx_cycle <= rx_cycle + 16'd1;
        if (rx_cycle[7:0] == 8'd0)
            rx_mode <= 2'($urandom_range(0, 3));
        case (rx_mode)
            2'd0:    out_ready <= 1'b1;
            2'd1:    out_ready <= ($urandom_range(0, 9) >= 3);
            2'd2:    out_ready <= ($urandom_range(0, 9) >= 8);
            default: out_ready <= (rx_cycle % 3 == 0);
        endcase
    end

    // Result checker
    always @(posedge clk)
    begin
        rx_result_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result with nothing pending: pop_valid=%0b id=%0h count=%0d",
                       pop_valid, out_id, overflow_count);
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (pop_valid !== want.pop_valid)
                begin
                    $error("pop_valid: expected %0b, got %0b", want.pop_valid, pop_valid);
                    mismatches++;
                end
                if (out_id !== want.id)
                begin
                    $error("out_id: expected %0h, got %0h", want.id, out_id);
                    mismatches++;
                end
                if (out_length !== want.len)
                begin
                    $error("out_length: expected %0d, got %0d", want.len, out_length);
                    mismatches++;
                end
                if (out_data !== want.data)
                begin
                    $error("out_data: expected %016h, got %016h", want.data, out_data);
                    mismatches++;
                end
                if (dropped !== want.dropped)
                begin
                    $error("dropped: expected %0b, got %0b", want.dropped, dropped);
                    mismatches++;
                end
                if (overflow_count !== want.count)
                begin
                    $error("overflow_count: expected %0d, got %0d", want.count, overflow_count);
                    mismatches++;
                end
            end
        end
    end

    // Watchdog on cycles with no handshake on either channel
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // Main sequence
    initial
    begin
        rx_item_t it;
        int       counted;
        int       push_pct;
        shadow_wr      = 0;
        shadow_rd      = 0;
        shadow_drops   = '0;
        shadow_enabled = 1'b0;
        mismatches     = 0;
        burst_left     = 0;
        idle_cycles    = 0;
        rx_cycle       = '0;
        rx_mode        = 2'd0;

        // Directed table; disabled after reset
        add_item(mk_item(OP_POP,  1'b0, 11'h7FF, 4'hF, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b1, 11'h7FF, 4'hF, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h7FF, 4'hF, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h000, 4'h0, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h555, 4'h8, 64'h0123_4567_89AB_CDEF), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h2AA, 4'h9, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h123, 4'h1, 64'hA5A5_A5A5_A5A5_A5A5), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h0F0, 4'h7, 64'hFEDC_BA98_7654_3210), 1, NO_FRAME);
        // pop while disabled with frames held
        add_item(mk_item(OP_POP,  1'b1, 11'h7FF, 4'hF, '1), 1, NO_FRAME);
        add_enable(1'b1);
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 1, frame_result(11'h7FF, 4'd8, '1));
        add_item(mk_item(OP_POP,  1'b1, 11'h7FF, 4'hF, '1), 1, frame_result(11'h000, 4'd0, '0));
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 1,
                 frame_result(11'h555, 4'd8, 64'h0123_4567_89AB_CDEF));
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 1, frame_result(11'h2AA, 4'd8, '1));
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 0, NO_FRAME);
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 0, NO_FRAME);
        // empty ring
        add_item(mk_item(OP_POP,  1'b0, 11'h7FF, 4'hF, '1), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b1, 11'h3C3, 4'h3, '1), 1, NO_FRAME);
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 1, NO_FRAME);
        add_item(mk_item(OP_PUSH, 1'b0, 11'h400, 4'h4, '1), 1, NO_FRAME);
        add_enable(1'b0);
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 1, NO_FRAME);
        add_enable(1'b1);
        add_item(mk_item(OP_POP,  1'b0, 11'h000, 4'h0, '0), 0, NO_FRAME);

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_ENABLE)
                set_enable(plan[i].en);
            else
                send_item(plan[i].item, plan[i].typed, plan[i].want);
        end

        // Random phases; extended pushes do not count toward a phase
        for (int ph = 0; ph < PHASE_COUNT; ph++)
        begin
            set_enable(PHASE_EN[ph]);
            push_pct = PHASE_PUSH_PCT[ph];
            counted  = 0;
            while (counted < PHASE_ITEMS)
            begin
                it.op   = ($urandom_range(0, 99) < push_pct) ? OP_PUSH : OP_POP;
                it.ext  = ($urandom_range(0, 9) == 0);
                it.id   = ID_W'($urandom_range(0, 2047));
                it.len  = LEN_W'($urandom_range(0, 15));
                it.data = {$urandom(), $urandom()};
                send_item(it, 0, NO_FRAME);
                if (!(it.op == OP_PUSH && it.ext))
                    counted++;
            end
        end

        // Drain and settle
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
